>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL of the normal-equation accumulator.
// No dependencies; defining SYNTH turns every macro into an empty body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define NEA_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("%m: property failed");
// Condition that must never be true outside reset.
`define NEA_ASSERT_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("%m: forbidden condition seen");
`else
`define NEA_ASSERT(label, clk, rstn, prop)
`define NEA_ASSERT_NEVER(label, clk, rstn, cond)
`endif
`endif

>>> rtl/nea_pkg.sv
// Package of the normal-equation accumulator: widths, codes, types and the
// saturating add and result-slot mapping used by the stages. No dependencies.
package nea_pkg;

    localparam int NUM_PARAMS_DEF = 6;
    localparam int NUM_PARAMS_MAX = 7;
    localparam int DERIV_FIELDS   = 6;
    localparam int SAMPLE_W       = 16;
    localparam int PROD_W         = 2 * SAMPLE_W;
    localparam int ACC_W          = 48;
    localparam int IDX_W          = 3;
    localparam int QTY_W          = 2;
    localparam int CFG_W          = 3;

    localparam int S_TDATA_W  = (1 + DERIV_FIELDS) * SAMPLE_W;
    localparam int M_TDATA_W  = ACC_W;
    localparam int M_TUSER_W  = QTY_W + 2 * IDX_W;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_PARAMS_IN_USE = '0;
    localparam logic [CFG_W-1:0]     PARAMS_RESET      = CFG_W'(6);

    localparam logic [QTY_W-1:0] QTY_CURV  = QTY_W'(0);
    localparam logic [QTY_W-1:0] QTY_GRAD  = QTY_W'(1);
    localparam logic [QTY_W-1:0] QTY_CHISQ = QTY_W'(2);

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [ACC_W-1:0]    acc_t;

    localparam acc_t ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam acc_t ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // Handshake state of one pipeline stage.
    typedef struct packed {
        logic valid;
        logic last;
    } stage_ctrl_t;

    // Signed add that clamps to the 48-bit limits instead of wrapping.
    function automatic acc_t sat_add(acc_t acc, prod_t p);
        logic signed [ACC_W:0] sum;
        acc_t                  res;
        sum = (ACC_W+1)'(acc) + (ACC_W+1)'(p);
        if (sum[ACC_W] != sum[ACC_W-1]) begin
            res = sum[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            res = acc_t'(sum[ACC_W-1:0]);
        end
        return res;
    endfunction

    // Number of result slots for a given parameter count.
    function automatic int num_slots(int np);
        return np * np + np + 1;
    endfunction

    // Source entry for result slot k when m parameters are emitted. Sources
    // are the matrix (np*np entries), the gradient (np), chi-square, and a
    // trailing zero entry for slots past the end of the result set.
    function automatic int slot_source(int k, int m, int np);
        int src;
        src = np * np + np + 1;
        if (k < m * m) begin
            for (int i = 0; i < NUM_PARAMS_MAX; i++) begin
                if (i < m && k >= i * m && k < (i + 1) * m) begin
                    src = i * np + (k - i * m);
                end
            end
        end else if (k < m * m + m) begin
            src = np * np + (k - m * m);
        end else if (k == m * m + m) begin
            src = np * np + np;
        end
        return src;
    endfunction

endpackage

>>> rtl/nea_products.sv
// Product stage: forms every derivative cross product, the negated
// derivative-residual products and the squared residual. Uses nea_pkg.
module nea_products #(
    parameter int NUM_PARAMS = nea_pkg::NUM_PARAMS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  nea_pkg::stage_ctrl_t  in_ctrl,
    input  nea_pkg::sample_t      residual,
    input  nea_pkg::sample_t      deriv [nea_pkg::DERIV_FIELDS],
    output logic                  in_ready,
    input  logic                  take,
    output nea_pkg::stage_ctrl_t  ctrl_reg,
    output nea_pkg::prod_t        cur_prod_reg [NUM_PARAMS*NUM_PARAMS],
    output nea_pkg::prod_t        grad_prod_reg [NUM_PARAMS],
    output nea_pkg::prod_t        chisq_prod_reg
);
    import nea_pkg::*;

    sample_t     d [NUM_PARAMS];
    stage_ctrl_t ctrl_next;
    logic        load;

    // Parameters beyond the available derivative fields see a zero derivative.
    for (genvar i = 0; i < NUM_PARAMS; i++) begin : g_deriv
        if (i < DERIV_FIELDS) begin : g_field
            assign d[i] = deriv[i];
        end else begin : g_zero
            assign d[i] = '0;
        end
    end

    assign in_ready  = !ctrl_reg.valid || take;
    assign load      = in_ready && in_ctrl.valid;
    assign ctrl_next = in_ready ? in_ctrl : ctrl_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else begin
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge aclk) begin
        logic signed [SAMPLE_W:0] r_neg;
        logic signed [PROD_W:0]   g_wide;
        r_neg = -((SAMPLE_W+1)'(residual));
        if (load) begin
            for (int i = 0; i < NUM_PARAMS; i++) begin
                for (int j = 0; j < NUM_PARAMS; j++) begin
                    cur_prod_reg[i*NUM_PARAMS+j] <= d[i] * d[j];
                end
                g_wide = r_neg * d[i];
                grad_prod_reg[i] <= prod_t'(g_wide[PROD_W-1:0]);
            end
            chisq_prod_reg <= residual * residual;
        end
    end

endmodule

>>> rtl/nea_accum.sv
// Accumulator bank: saturating sums of the curvature matrix, the negated
// gradient and chi-square, cleared after a run ends. Uses nea_pkg.
`include "assert_macros.svh"

module nea_accum #(
    parameter int NUM_PARAMS = nea_pkg::NUM_PARAMS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  nea_pkg::stage_ctrl_t  ctrl,
    input  nea_pkg::prod_t        cur_prod [NUM_PARAMS*NUM_PARAMS],
    input  nea_pkg::prod_t        grad_prod [NUM_PARAMS],
    input  nea_pkg::prod_t        chisq_prod,
    input  logic                  emit_busy,
    output logic                  take,
    output logic                  dump_reg,
    output nea_pkg::acc_t         cur_reg [NUM_PARAMS*NUM_PARAMS],
    output nea_pkg::acc_t         grad_reg [NUM_PARAMS],
    output nea_pkg::acc_t         chisq_reg
);
    import nea_pkg::*;

    localparam int NSQ = NUM_PARAMS * NUM_PARAMS;

    logic fire;
    logic dump_next;
    acc_t cur_next [NSQ];
    acc_t grad_next [NUM_PARAMS];
    acc_t chisq_next;

    // A last row may only complete once the emitter can take a new snapshot.
    assign take      = !ctrl.valid || !ctrl.last || (!emit_busy && !dump_reg);
    assign fire      = ctrl.valid && take;
    assign dump_next = fire && ctrl.last;

    // In the cycle after a run ends the emitter copies the sums, so they
    // restart from zero here.
    always_comb begin
        for (int k = 0; k < NSQ; k++) begin
            cur_next[k] = sat_add(dump_reg ? acc_t'('0) : cur_reg[k],
                                  fire ? cur_prod[k] : prod_t'('0));
        end
        for (int k = 0; k < NUM_PARAMS; k++) begin
            grad_next[k] = sat_add(dump_reg ? acc_t'('0) : grad_reg[k],
                                   fire ? grad_prod[k] : prod_t'('0));
        end
        chisq_next = sat_add(dump_reg ? acc_t'('0) : chisq_reg,
                             fire ? chisq_prod : prod_t'('0));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dump_reg  <= 1'b0;
            chisq_reg <= '0;
            for (int k = 0; k < NSQ; k++) begin
                cur_reg[k] <= '0;
            end
            for (int k = 0; k < NUM_PARAMS; k++) begin
                grad_reg[k] <= '0;
            end
        end else begin
            dump_reg  <= dump_next;
            chisq_reg <= chisq_next;
            for (int k = 0; k < NSQ; k++) begin
                cur_reg[k] <= cur_next[k];
            end
            for (int k = 0; k < NUM_PARAMS; k++) begin
                grad_reg[k] <= grad_next[k];
            end
        end
    end

    `NEA_ASSERT(a_dump_needs_idle_emitter, aclk, aresetn, dump_reg |-> !emit_busy)
    `NEA_ASSERT(a_clear_after_dump, aclk, aresetn, (dump_reg && !fire) |=> (chisq_reg == '0))
    `NEA_ASSERT_NEVER(a_chisq_negative, aclk, aresetn, chisq_reg[ACC_W-1])

endmodule

>>> rtl/nea_emitter.sv
// Result emitter: snapshots the sums of a finished run into a shift line
// and streams them out with their quantity and indices. Uses nea_pkg.
`include "assert_macros.svh"

module nea_emitter #(
    parameter int NUM_PARAMS = nea_pkg::NUM_PARAMS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         load,
    input  logic [nea_pkg::IDX_W-1:0]    n_eff,
    input  nea_pkg::acc_t                cur_sum [NUM_PARAMS*NUM_PARAMS],
    input  nea_pkg::acc_t                grad_sum [NUM_PARAMS],
    input  nea_pkg::acc_t                chisq_sum,
    output logic                         busy,
    output logic                         m_valid,
    input  logic                         m_ready,
    output nea_pkg::acc_t                m_value,
    output logic [nea_pkg::QTY_W-1:0]    m_qty,
    output logic [nea_pkg::IDX_W-1:0]    m_row,
    output logic [nea_pkg::IDX_W-1:0]    m_col,
    output logic                         m_last
);
    import nea_pkg::*;

    localparam int NSQ   = NUM_PARAMS * NUM_PARAMS;
    localparam int SLOTS = num_slots(NUM_PARAMS);

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_CURV  = 4'b0010,
        PH_GRAD  = 4'b0100,
        PH_CHISQ = 4'b1000
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [IDX_W-1:0] row_reg, row_next;
    logic [IDX_W-1:0] col_reg, col_next;
    logic [IDX_W-1:0] n_reg, n_next;
    logic [IDX_W-1:0] n_last;
    logic             advance;
    acc_t             src [SLOTS+1];
    acc_t             load_val [SLOTS];
    acc_t             chain_reg [SLOTS];

    // Flat source list: matrix, gradient, chi-square, then a zero entry.
    always_comb begin
        for (int k = 0; k < NSQ; k++) begin
            src[k] = cur_sum[k];
        end
        for (int k = 0; k < NUM_PARAMS; k++) begin
            src[NSQ+k] = grad_sum[k];
        end
        src[NSQ+NUM_PARAMS]   = chisq_sum;
        src[NSQ+NUM_PARAMS+1] = '0;
    end

    // Each slot picks among a handful of fixed sources by parameter count,
    // so the line holds the results in emission order with no gaps.
    always_comb begin
        for (int k = 0; k < SLOTS; k++) begin
            load_val[k] = '0;
            for (int m = 1; m <= NUM_PARAMS; m++) begin
                if (n_eff == IDX_W'(m)) begin
                    load_val[k] = src[slot_source(k, m, NUM_PARAMS)];
                end
            end
        end
    end

    assign busy    = (phase_reg != PH_IDLE);
    assign advance = busy && m_ready;
    assign n_last  = n_reg - IDX_W'(1);

    always_ff @(posedge aclk) begin
        if (load) begin
            for (int k = 0; k < SLOTS; k++) begin
                chain_reg[k] <= load_val[k];
            end
        end else if (advance) begin
            for (int k = 0; k < SLOTS - 1; k++) begin
                chain_reg[k] <= chain_reg[k+1];
            end
            chain_reg[SLOTS-1] <= '0;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        n_next     = n_reg;
        if (load) begin
            phase_next = PH_CURV;
            row_next   = '0;
            col_next   = '0;
            n_next     = n_eff;
        end else if (advance) begin
            unique case (phase_reg)
                PH_CURV: begin
                    if (col_reg == n_last) begin
                        col_next = '0;
                        if (row_reg == n_last) begin
                            row_next   = '0;
                            phase_next = PH_GRAD;
                        end else begin
                            row_next = row_reg + IDX_W'(1);
                        end
                    end else begin
                        col_next = col_reg + IDX_W'(1);
                    end
                end
                PH_GRAD: begin
                    if (row_reg == n_last) begin
                        row_next   = '0;
                        phase_next = PH_CHISQ;
                    end else begin
                        row_next = row_reg + IDX_W'(1);
                    end
                end
                PH_CHISQ: begin
                    phase_next = PH_IDLE;
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
            n_reg     <= IDX_W'(1);
        end else begin
            phase_reg <= phase_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            n_reg     <= n_next;
        end
    end

    always_comb begin
        unique case (phase_reg)
            PH_CURV:  m_qty = QTY_CURV;
            PH_GRAD:  m_qty = QTY_GRAD;
            PH_CHISQ: m_qty = QTY_CHISQ;
            default:  m_qty = QTY_CURV;
        endcase
    end

    assign m_valid = busy;
    assign m_value = chain_reg[0];
    assign m_row   = row_reg;
    assign m_col   = col_reg;
    assign m_last  = (phase_reg == PH_CHISQ);

    `NEA_ASSERT(a_load_when_idle, aclk, aresetn, load |-> (phase_reg == PH_IDLE))
    `NEA_ASSERT(a_idle_after_chisq, aclk, aresetn, (m_valid && m_ready && m_last) |=> !m_valid)
    `NEA_ASSERT(a_index_in_range, aclk, aresetn, m_valid |-> ((row_reg < n_reg) && (col_reg < n_reg)))

endmodule

>>> rtl/normal_equation_accumulator_top.sv
// Top level of the normal-equation accumulator: stream ports, APB register,
// input register. Uses nea_pkg, nea_products, nea_accum and nea_emitter.
//
// The block takes one Jacobian row per request (a Q1.15 residual and the
// Q1.15 derivatives) and accumulates J^T J, -J^T r and chi-square in
// saturating 48-bit Q18.30 sums. It accepts one row in every clock cycle:
// each row passes an input register, a product register (one 16x16
// multiplier per product) and the accumulator register (one 48-bit
// saturating add per sum), so rows stream back to back. A row marked
// with tlast closes the run; once its products are summed the emitter
// copies the sums into its output shift line, the sums restart from zero,
// and n*n + n + 1 results leave at one per cycle while m_tready is high:
// the matrix row by row, then the gradient, then chi-square with tlast set.
// New rows keep flowing into the fresh sums while results drain. Only the
// next row marked last waits in the product register until the previous
// result set has been fully taken, and the rows behind it wait with it.
// The number of parameters emitted is set by params_in_use, where zero
// reads as one and values above NUM_PARAMS read as NUM_PARAMS; it should
// be written only while the block is idle. There is no clearing pass after
// reset.
module normal_equation_accumulator_top #(
    parameter int NUM_PARAMS = nea_pkg::NUM_PARAMS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input rows.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // residual [15:0], deriv_0 [31:16], deriv_1 [47:32], deriv_2 [63:48],
    // deriv_3 [79:64], deriv_4 [95:80], deriv_5 [111:96]
    input  logic [nea_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                              s_tlast,       // last_row
    // Results.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [nea_pkg::M_TDATA_W-1:0]     m_tdata,       // value [47:0]
    // quantity [1:0], row_index [4:2], col_index [7:5]
    output logic [nea_pkg::M_TUSER_W-1:0]     m_tuser,
    output logic                              m_tlast,       // last_result
    // Register port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [nea_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [nea_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [nea_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import nea_pkg::*;

    localparam int NSQ = NUM_PARAMS * NUM_PARAMS;

    // Configuration register.
    logic [CFG_W-1:0]     params_reg;
    logic [REG_IDX_W-1:0] reg_index;
    logic                 cfg_write;
    logic [IDX_W-1:0]     n_eff;

    // Input register.
    stage_ctrl_t in_ctrl_reg, in_ctrl_next;
    sample_t     residual_reg;
    sample_t     deriv_reg [DERIV_FIELDS];
    logic        s_accept;

    // Stage interconnect.
    logic        prod_ready;
    logic        acc_take;
    stage_ctrl_t prod_ctrl;
    prod_t       cur_prod [NSQ];
    prod_t       grad_prod [NUM_PARAMS];
    prod_t       chisq_prod;
    logic        dump;
    acc_t        cur_sum [NSQ];
    acc_t        grad_sum [NUM_PARAMS];
    acc_t        chisq_sum;
    logic        emit_busy;
    acc_t        m_value;
    logic [QTY_W-1:0] m_qty;
    logic [IDX_W-1:0] m_row;
    logic [IDX_W-1:0] m_col;

    // The register is written in the access phase of an APB write; reads
    // return it zero-extended, and the other register index reads as zero.
    assign pready    = 1'b1;
    assign reg_index = paddr[APB_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            params_reg <= PARAMS_RESET;
        end else if (cfg_write && reg_index == REG_PARAMS_IN_USE) begin
            params_reg <= pwdata[CFG_W-1:0];
        end
    end

    always_comb begin
        if (reg_index == REG_PARAMS_IN_USE) begin
            prdata = APB_DATA_W'(params_reg);
        end else begin
            prdata = '0;
        end
    end

    // Zero parameters is treated as one, and counts past the matrix size
    // are clipped to it.
    always_comb begin
        priority if (params_reg == '0) begin
            n_eff = IDX_W'(1);
        end else if (params_reg > CFG_W'(NUM_PARAMS)) begin
            n_eff = IDX_W'(NUM_PARAMS);
        end else begin
            n_eff = IDX_W'(params_reg);
        end
    end

    // The input register takes a new request whenever it is empty or its
    // row moves on into the product stage in the same cycle.
    assign s_tready = !in_ctrl_reg.valid || prod_ready;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_ctrl_next = in_ctrl_reg;
        if (s_tready) begin
            in_ctrl_next.valid = s_tvalid;
            in_ctrl_next.last  = s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_ctrl_reg <= '0;
        end else begin
            in_ctrl_reg <= in_ctrl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            residual_reg <= sample_t'(s_tdata[SAMPLE_W-1:0]);
            for (int f = 0; f < DERIV_FIELDS; f++) begin
                deriv_reg[f] <= sample_t'(s_tdata[(f+1)*SAMPLE_W +: SAMPLE_W]);
            end
        end
    end

    nea_products #(
        .NUM_PARAMS (NUM_PARAMS)
    ) u_products (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_ctrl        (in_ctrl_reg),
        .residual       (residual_reg),
        .deriv          (deriv_reg),
        .in_ready       (prod_ready),
        .take           (acc_take),
        .ctrl_reg       (prod_ctrl),
        .cur_prod_reg   (cur_prod),
        .grad_prod_reg  (grad_prod),
        .chisq_prod_reg (chisq_prod)
    );

    nea_accum #(
        .NUM_PARAMS (NUM_PARAMS)
    ) u_accum (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (prod_ctrl),
        .cur_prod   (cur_prod),
        .grad_prod  (grad_prod),
        .chisq_prod (chisq_prod),
        .emit_busy  (emit_busy),
        .take       (acc_take),
        .dump_reg   (dump),
        .cur_reg    (cur_sum),
        .grad_reg   (grad_sum),
        .chisq_reg  (chisq_sum)
    );

    nea_emitter #(
        .NUM_PARAMS (NUM_PARAMS)
    ) u_emitter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (dump),
        .n_eff     (n_eff),
        .cur_sum   (cur_sum),
        .grad_sum  (grad_sum),
        .chisq_sum (chisq_sum),
        .busy      (emit_busy),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_value   (m_value),
        .m_qty     (m_qty),
        .m_row     (m_row),
        .m_col     (m_col),
        .m_last    (m_tlast)
    );

    assign m_tdata = M_TDATA_W'(m_value);
    assign m_tuser = {m_col, m_row, m_qty};

endmodule

>>> bench/tb.sv
// Self-checking bench for normal_equation_accumulator_top: streams Jacobian rows,
// predicts the emitted sums and compares every result with the prediction.
// Depends on nea_pkg and the RTL of the accumulator only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nea_pkg::*;

    localparam int     NP            = NUM_PARAMS_DEF;
    localparam int     SETTLE_CYCLES = 12;
    localparam int     CYCLE_LIMIT   = 1000000;
    // A short run of full-scale rows with mixed signs.
    localparam int     SAT_ROWS      = 8;
    localparam int     RANDOM_PHASES = 12;
    // Register index that decodes to no register.
    localparam logic [REG_IDX_W-1:0] REG_UNUSED = REG_IDX_W'(1);
    localparam longint SUM_MAX = longint'(ACC_MAX);
    localparam longint SUM_MIN = longint'(ACC_MIN);

    // One Jacobian row as it travels on the input stream.
    typedef struct packed {
        logic                 last_row;
        logic [5:0][15:0]     deriv;
        logic [15:0]          residual;
    } jac_row_t;

    // One emitted sum with its tags.
    typedef struct packed {
        logic [QTY_W-1:0] quantity;
        logic [IDX_W-1:0] row_index;
        logic [IDX_W-1:0] col_index;
        logic [ACC_W-1:0] value;
        logic             last_result;
    } nea_result_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic                  s_tlast  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  m_tlast;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Predicted state of the block.
    longint           curv_sum [NP][NP];
    longint           grad_sum [NP];
    longint           chisq_acc;
    logic [CFG_W-1:0] param_count;

    jac_row_t    pending_rows[$];
    nea_result_t expected_sums[$];
    jac_row_t    row_on_bus;
    nea_result_t want;
    logic        load_row;
    int          src_gap, sink_gap;
    int          src_idle_pct  = 0;
    int          sink_idle_pct = 0;
    int          error_count   = 0;
    int          cycle_count   = 0;

    normal_equation_accumulator_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    task automatic flag_error(input string msg);
        error_count++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    function automatic longint clamp48(input longint s);
        longint res;
        res = s;
        if (s > SUM_MAX) res = SUM_MAX;
        if (s < SUM_MIN) res = SUM_MIN;
        return res;
    endfunction

    // Adds one row into the predicted sums. A row marked last queues the whole
    // result set (matrix, gradient, chi-square) and then clears the sums.
    task automatic accumulate_row(input jac_row_t row);
        longint      r;
        longint      d [NP];
        int          n, i, j;
        nea_result_t e;
        r = longint'(signed'(row.residual));
        for (i = 0; i < NP; i++) begin
            d[i] = longint'(signed'(row.deriv[i]));
        end
        for (i = 0; i < NP; i++) begin
            for (j = 0; j < NP; j++) begin
                curv_sum[i][j] = clamp48(curv_sum[i][j] + d[i] * d[j]);
            end
            grad_sum[i] = clamp48(grad_sum[i] - d[i] * r);
        end
        chisq_acc = clamp48(chisq_acc + r * r);
        if (row.last_row) begin
            // A count of zero reads as one, anything above the size as the size.
            n = int'(param_count);
            if (n < 1) n = 1;
            if (n > NP) n = NP;
            e = '0;
            for (i = 0; i < n; i++) begin
                for (j = 0; j < n; j++) begin
                    e.quantity  = QTY_CURV;
                    e.row_index = IDX_W'(i);
                    e.col_index = IDX_W'(j);
                    e.value     = curv_sum[i][j][ACC_W-1:0];
                    expected_sums.push_back(e);
                end
            end
            for (i = 0; i < n; i++) begin
                e.quantity  = QTY_GRAD;
                e.row_index = IDX_W'(i);
                e.col_index = '0;
                e.value     = grad_sum[i][ACC_W-1:0];
                expected_sums.push_back(e);
            end
            e.quantity    = QTY_CHISQ;
            e.row_index   = '0;
            e.value       = chisq_acc[ACC_W-1:0];
            e.last_result = 1'b1;
            expected_sums.push_back(e);
            for (i = 0; i < NP; i++) begin
                for (j = 0; j < NP; j++) begin
                    curv_sum[i][j] = 0;
                end
                grad_sum[i] = 0;
            end
            chisq_acc = 0;
        end
    endtask

    // Row source: holds a row until it is taken, inserts random idle bursts.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                accumulate_row(row_on_bus);
            end
            if (!s_tvalid || s_tready) begin
                load_row = 1'b0;
                if (src_gap != 0) begin
                    src_gap--;
                end else if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
                    src_gap = $urandom_range(7);
                end else if (pending_rows.size() != 0) begin
                    load_row   = 1'b1;
                    row_on_bus = pending_rows.pop_front();
                    s_tdata <= {row_on_bus.deriv, row_on_bus.residual};
                    s_tlast <= row_on_bus.last_row;
                end
                s_tvalid <= load_row;
            end
        end
    end

    // Result sink: checks every accepted result against the oldest prediction.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            sink_gap = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_sums.size() == 0) begin
                    flag_error($sformatf("result with nothing pending: tuser %0h value %0h",
                                         m_tuser, m_tdata));
                end else begin
                    want = expected_sums.pop_front();
                    if (m_tuser[1:0] !== want.quantity)
                        flag_error($sformatf("quantity %0d, expected %0d",
                                             m_tuser[1:0], want.quantity));
                    if (m_tuser[4:2] !== want.row_index)
                        flag_error($sformatf("row_index %0d, expected %0d",
                                             m_tuser[4:2], want.row_index));
                    if (m_tuser[7:5] !== want.col_index)
                        flag_error($sformatf("col_index %0d, expected %0d",
                                             m_tuser[7:5], want.col_index));
                    if (m_tdata !== want.value)
                        flag_error($sformatf("value %h at q%0d r%0d c%0d, expected %h",
                                             m_tdata, want.quantity, want.row_index,
                                             want.col_index, want.value));
                    if (m_tlast !== want.last_result)
                        flag_error($sformatf("last_result %b, expected %b",
                                             m_tlast, want.last_result));
                end
            end
            if (sink_gap != 0) begin
                sink_gap--;
                m_tready <= 1'b0;
            end else if (sink_idle_pct != 0 && $urandom_range(99) < sink_idle_pct) begin
                sink_gap = $urandom_range(7);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Waits until every row is taken and every result is in, then lets the
    // pipeline drain rows that produce no result. Returns at a falling edge.
    task automatic wait_idle();
        while (pending_rows.size() != 0 || s_tvalid || expected_sums.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_PARAMS_IN_USE) param_count = val[CFG_W-1:0];
        @(negedge aclk);
    endtask

    // Favors full scale, zero and values near zero over plain random words.
    function automatic logic [15:0] pick_sample();
        logic [15:0] v;
        case ($urandom_range(7))
            0: v = 16'h8000;
            1: v = 16'h7FFF;
            2: v = 16'h0000;
            3: v = 16'($urandom_range(16)) - 16'd8;
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    function automatic jac_row_t random_row(input logic last_row);
        jac_row_t row;
        row.residual = pick_sample();
        for (int i = 0; i < 6; i++) row.deriv[i] = pick_sample();
        row.last_row = last_row;
        return row;
    endfunction

    function automatic jac_row_t uniform_row(input logic [15:0] v, input logic last_row);
        jac_row_t row;
        row.residual = v;
        row.deriv    = {6{v}};
        row.last_row = last_row;
        return row;
    endfunction

    initial begin
        jac_row_t row;
        int       phase, run_len, rows_in_phase, k;
        for (int i = 0; i < NP; i++) begin
            for (int j = 0; j < NP; j++) curv_sum[i][j] = 0;
            grad_sum[i] = 0;
        end
        chisq_acc   = 0;
        param_count = PARAMS_RESET;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part, first with the reset count of six parameters:
        // full-scale negative and positive rows, a mixed run and a zero row.
        src_idle_pct  = 20;
        sink_idle_pct = 20;
        pending_rows.push_back(uniform_row(16'h8000, 1'b1));
        pending_rows.push_back(uniform_row(16'h7FFF, 1'b1));
        row.residual = 16'h8000;
        row.deriv    = {16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF, 16'h0000, 16'h7FFF};
        row.last_row = 1'b0;
        pending_rows.push_back(row);
        row.residual = 16'h7FFF;
        row.deriv    = {16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001, 16'h8000, 16'h0000};
        pending_rows.push_back(row);
        row.residual = 16'hFFFF;
        row.deriv    = {16'h5555, 16'hAAAA, 16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF};
        row.last_row = 1'b1;
        pending_rows.push_back(row);
        pending_rows.push_back(uniform_row(16'h0000, 1'b1));
        wait_idle();

        // A count of zero emits a single parameter; the unused derivatives
        // still accumulate and must be cleared with the rest.
        write_reg(REG_PARAMS_IN_USE, 32'd0);
        pending_rows.push_back(uniform_row(16'h8000, 1'b0));
        pending_rows.push_back(random_row(1'b1));
        pending_rows.push_back(random_row(1'b1));
        wait_idle();

        // A count above the size reads as the size.
        write_reg(REG_PARAMS_IN_USE, 32'd7);
        pending_rows.push_back(random_row(1'b1));
        wait_idle();

        // A write to an index with no register leaves the count alone.
        write_reg(REG_UNUSED, 32'd2);
        pending_rows.push_back(random_row(1'b0));
        pending_rows.push_back(random_row(1'b1));
        wait_idle();

        write_reg(REG_PARAMS_IN_USE, 32'd3);
        pending_rows.push_back(random_row(1'b0));
        pending_rows.push_back(random_row(1'b1));
        wait_idle();

        // Full scale: a back-to-back run of full-scale rows with mixed signs
        // builds large sums of both signs, then random rows close the run.
        write_reg(REG_PARAMS_IN_USE, 32'd6);
        src_idle_pct = 0;
        row.residual = 16'h8000;
        row.deriv    = {16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000};
        row.last_row = 1'b0;
        for (k = 0; k < SAT_ROWS; k++) pending_rows.push_back(row);
        pending_rows.push_back(random_row(1'b0));
        pending_rows.push_back(random_row(1'b0));
        pending_rows.push_back(random_row(1'b1));
        wait_idle();

        // Random part: each phase picks a count, idle levels and a set of runs
        // of mostly short length; the last phases run without any idling.
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            write_reg(REG_PARAMS_IN_USE,
                      ($urandom & ~32'h7) | 32'($urandom_range(7)));
            if (phase >= RANDOM_PHASES - 2) begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end else begin
                case ($urandom_range(3))
                    0: src_idle_pct = 0;
                    1: src_idle_pct = 10;
                    2: src_idle_pct = 30;
                    default: src_idle_pct = 60;
                endcase
                case ($urandom_range(3))
                    0: sink_idle_pct = 0;
                    1: sink_idle_pct = 10;
                    2: sink_idle_pct = 30;
                    default: sink_idle_pct = 60;
                endcase
            end
            rows_in_phase = 0;
            while (rows_in_phase < 26) begin
                run_len = ($urandom_range(3) == 0) ? 1 : $urandom_range(12, 2);
                for (k = 0; k < run_len; k++) begin
                    pending_rows.push_back(random_row(k == run_len - 1));
                end
                rows_in_phase += run_len;
            end
            wait_idle();
        end

        if (error_count == 0) begin
            $display("normal_equation_accumulator_top regression: pass");
        end else begin
            $display("normal_equation_accumulator_top regression: fail");
        end
        $finish;
    end

    // Watchdog on the whole run.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("normal_equation_accumulator_top regression: fail");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/nea_pkg.sv
rtl/nea_products.sv
rtl/nea_accum.sv
rtl/nea_emitter.sv
rtl/normal_equation_accumulator_top.sv
bench/tb.sv
